// ===== sv/euler_to_quaternion_unit_defines.svh =====
// Assertion macros shared by the Euler to quaternion unit.
`ifndef EULER_TO_QUATERNION_UNIT_DEFINES_SVH
`define EULER_TO_QUATERNION_UNIT_DEFINES_SVH
// Assert that an implication holds at every clock edge outside reset.
`define E2Q_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that the consequent holds in the cycle after the antecedent.
`define E2Q_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/e2q_pkg.sv =====
// Package with payload types and fixed-point constants of the Euler to quaternion unit.
`timescale 1ns / 1ps
package e2q_pkg;
    typedef struct packed {
        logic signed [15:0] roll_deg;
        logic signed [15:0] pitch_deg;
        logic signed [15:0] yaw_deg;
    } t_in;
    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_out;
    localparam int TableLen = 24;
    localparam logic signed [35:0] DegHalfToRad = 36'sd146409;
    localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
    localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
    localparam logic signed [33:0] CordicInvGain = 34'sd652032874;
    typedef logic signed [35:0] t_atan_tab [TableLen];
    localparam t_atan_tab AtanQ30 = '{
        36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
        36'sd67021686, 36'sd33543515, 36'sd16775850, 36'sd8388437,
        36'sd4194282, 36'sd2097149, 36'sd1048575, 36'sd524287,
        36'sd262143, 36'sd131071, 36'sd65535, 36'sd32767,
        36'sd16383, 36'sd8191, 36'sd4095, 36'sd2047,
        36'sd1023, 36'sd511, 36'sd255, 36'sd127};
endpackage

// ===== sv/euler_to_quaternion_unit.sv =====
// Throughput: one request per cycle; the whole pipeline advances when the output
// register is free or being taken, so a stall holds every stage in place.
// Each CORDIC stage, product stage and output stage is one register level.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`include "euler_to_quaternion_unit_defines.svh"
module euler_to_quaternion_unit #(
    parameter int CORDIC_STAGES = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  e2q_pkg::t_in    i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output e2q_pkg::t_out   o_data
);
    localparam int NStg = (CORDIC_STAGES < e2q_pkg::TableLen) ?
        CORDIC_STAGES : e2q_pkg::TableLen;
    localparam int Depth = NStg + 8;
    localparam int Sh = 30 - OUT_FRAC_BITS;

    // Pipeline advances when the last stage is empty or being taken.
    logic             w_adv;
    logic [Depth-1:0] r_vld;
    assign w_adv = !r_vld[Depth-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[Depth-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
        end
    end

    // Stage 0: scale each half angle to Q30 radians.
    logic signed [35:0] r_th [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_th[0] <= 36'(i_data.roll_deg) * e2q_pkg::DegHalfToRad;
            r_th[1] <= 36'(i_data.pitch_deg) * e2q_pkg::DegHalfToRad;
            r_th[2] <= 36'(i_data.yaw_deg) * e2q_pkg::DegHalfToRad;
        end
    end

    // Stage 1: fold into the CORDIC range and seed the rotation.
    logic signed [35:0] r_x [NStg+1][3];
    logic signed [35:0] r_y [NStg+1][3];
    logic signed [35:0] r_z [NStg+1][3];
    logic [2:0]         r_fl [NStg+1];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_x[0][k] <= 36'(e2q_pkg::CordicInvGain);
                r_y[0][k] <= '0;
                if (r_th[k] > e2q_pkg::HalfPiQ30) begin
                    r_z[0][k]  <= r_th[k] - e2q_pkg::PiQ30;
                    r_fl[0][k] <= 1'b1;
                end else if (r_th[k] < -e2q_pkg::HalfPiQ30) begin
                    r_z[0][k]  <= r_th[k] + e2q_pkg::PiQ30;
                    r_fl[0][k] <= 1'b1;
                end else begin
                    r_z[0][k]  <= r_th[k];
                    r_fl[0][k] <= 1'b0;
                end
            end
        end
    end

    // CORDIC rotation stages, one micro-rotation per register level.
    for (genvar g = 0; g < NStg; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_fl[g+1] <= r_fl[g];
                for (int k = 0; k < 3; k++) begin
                    if (r_z[g][k] >= 0) begin
                        r_x[g+1][k] <= r_x[g][k] - (r_y[g][k] >>> g);
                        r_y[g+1][k] <= r_y[g][k] + (r_x[g][k] >>> g);
                        r_z[g+1][k] <= r_z[g][k] - e2q_pkg::AtanQ30[g];
                    end else begin
                        r_x[g+1][k] <= r_x[g][k] + (r_y[g][k] >>> g);
                        r_y[g+1][k] <= r_y[g][k] - (r_x[g][k] >>> g);
                        r_z[g+1][k] <= r_z[g][k] + e2q_pkg::AtanQ30[g];
                    end
                end
            end
        end
    end

    // Apply the fold sign; index 0 roll, 1 pitch, 2 yaw.
    logic signed [32:0] r_c [3];
    logic signed [32:0] r_s [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= r_fl[NStg][k] ? 33'(-r_x[NStg][k]) : 33'(r_x[NStg][k]);
                r_s[k] <= r_fl[NStg][k] ? 33'(-r_y[NStg][k]) : 33'(r_y[NStg][k]);
            end
        end
    end

    // First products: yaw times roll terms, and carry pitch terms along.
    logic signed [32:0] r_p1 [4];
    logic signed [32:0] r_cp, r_sp;
    logic signed [65:0] w_m1 [4];
    always_comb begin
        w_m1[0] = 66'(r_c[2]) * 66'(r_c[0]);
        w_m1[1] = 66'(r_s[2]) * 66'(r_s[0]);
        w_m1[2] = 66'(r_c[2]) * 66'(r_s[0]);
        w_m1[3] = 66'(r_s[2]) * 66'(r_c[0]);
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 4; k++) begin
                r_p1[k] <= 33'(w_m1[k] >>> 30);
            end
            r_cp <= r_c[1];
            r_sp <= r_s[1];
        end
    end

    // Second products with the pitch terms.
    logic signed [32:0] r_p2 [8];
    logic signed [65:0] w_m2 [8];
    always_comb begin
        w_m2[0] = 66'(r_p1[0]) * 66'(r_cp);
        w_m2[1] = 66'(r_p1[1]) * 66'(r_sp);
        w_m2[2] = 66'(r_p1[2]) * 66'(r_cp);
        w_m2[3] = 66'(r_p1[3]) * 66'(r_sp);
        w_m2[4] = 66'(r_p1[0]) * 66'(r_sp);
        w_m2[5] = 66'(r_p1[1]) * 66'(r_cp);
        w_m2[6] = 66'(r_p1[3]) * 66'(r_cp);
        w_m2[7] = 66'(r_p1[2]) * 66'(r_sp);
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 8; k++) begin
                r_p2[k] <= 33'(w_m2[k] >>> 30);
            end
        end
    end

    // Sum the product pairs.
    logic signed [34:0] r_sum [4];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum[0] <= 35'(r_p2[0]) + 35'(r_p2[1]);
            r_sum[1] <= 35'(r_p2[2]) - 35'(r_p2[3]);
            r_sum[2] <= 35'(r_p2[4]) + 35'(r_p2[5]);
            r_sum[3] <= 35'(r_p2[6]) - 35'(r_p2[7]);
        end
    end

    // Round to the output format.
    logic signed [35:0] r_rnd [4];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 4; k++) begin
                if (Sh > 0) begin
                    r_rnd[k] <= (36'(r_sum[k]) + (36'sd1 <<< (Sh - 1))) >>> Sh;
                end else begin
                    r_rnd[k] <= 36'(r_sum[k]);
                end
            end
        end
    end

    // Saturate and register the result.
    localparam logic signed [35:0] Lim = 36'sd1 <<< OUT_FRAC_BITS;
    logic [15:0]   w_q [4];
    e2q_pkg::t_out r_out;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_rnd[k] > Lim) begin
                w_q[k] = Lim[15:0];
            end else if (r_rnd[k] < -Lim) begin
                w_q[k] = 16'(-Lim);
            end else begin
                w_q[k] = r_rnd[k][15:0];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.quat_w <= w_q[0];
            r_out.quat_x <= w_q[1];
            r_out.quat_y <= w_q[2];
            r_out.quat_z <= w_q[3];
        end
    end
    assign o_data = r_out;

    // A stalled result must hold its valid.
    `E2Q_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped")
    // An accepted request reaches stage 0.
    `E2Q_ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_valid && o_ready, r_vld[0], "request lost")
    // Ready follows the output stage.
    `E2Q_ASSERT_IMPL(a_rdy, i_clk, i_rst_n, !o_valid, o_ready, "ready low on empty output")
endmodule

// ===== sim/tb_euler_to_quaternion_unit.sv =====
// Self-checking testbench for the Euler angle to quaternion conversion unit.
`timescale 1ns / 1ps
module tb_euler_to_quaternion_unit;

    localparam int NumStages = 16;
    localparam int FracBits = 14;
    localparam int Latency = NumStages + 7;
    localparam int NumRandom = 1430;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    e2q_pkg::t_in i_data;
    logic o_valid;
    logic i_ready;
    e2q_pkg::t_out o_data;

    euler_to_quaternion_unit #(
        .CORDIC_STAGES(NumStages),
        .OUT_FRAC_BITS(FracBits)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    e2q_pkg::t_in angle_queue[$];
    e2q_pkg::t_out quat_queue[$];
    bit stimulus_done;
    int mismatches;
    int results_seen;
    int requests_sent;
    int hold_off;
    int send_gap;
    int take_gap;

    // Floor shift right of a signed 64-bit value.
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    // Cosine and sine of half an angle, Q30.
    function automatic void half_angle_trig(logic signed [15:0] ang,
                                            output longint c, output longint s);
        longint z, x, y, nx;
        bit flip;
        z = longint'(ang) * 146409;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < NumStages && i < e2q_pkg::TableLen; i++) begin
            if (z >= 0) begin
                nx = x - shr_floor(y, i);
                y = y + shr_floor(x, i);
                z -= longint'(e2q_pkg::AtanQ30[i]);
            end else begin
                nx = x + shr_floor(y, i);
                y = y - shr_floor(x, i);
                z += longint'(e2q_pkg::AtanQ30[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint triple_product(longint a, longint b, longint c);
        return shr_floor(shr_floor(a * b, 30) * c, 30);
    endfunction

    // Round to the output format and clamp to plus or minus one.
    function automatic logic signed [15:0] round_saturate(longint v);
        longint lim;
        lim = longint'(1) << FracBits;
        v = shr_floor(v + (longint'(1) << (29 - FracBits)), 30 - FracBits);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[15:0];
    endfunction

    function automatic e2q_pkg::t_out predict_quaternion(e2q_pkg::t_in a);
        longint cr, sr, cp, sp, cy, sy;
        e2q_pkg::t_out q;
        half_angle_trig(a.roll_deg, cr, sr);
        half_angle_trig(a.pitch_deg, cp, sp);
        half_angle_trig(a.yaw_deg, cy, sy);
        q.quat_w = round_saturate(triple_product(cy, cr, cp) + triple_product(sy, sr, sp));
        q.quat_x = round_saturate(triple_product(cy, sr, cp) - triple_product(sy, cr, sp));
        q.quat_y = round_saturate(triple_product(cy, cr, sp) + triple_product(sy, sr, cp));
        q.quat_z = round_saturate(triple_product(sy, cr, cp) - triple_product(cy, sr, sp));
        return q;
    endfunction

    function automatic logic [15:0] random_angle();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 46080)) - 23040);
            2: return 16'($signed($urandom_range(0, 2000)) - 1000);
            default: return 16'($signed($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    function automatic e2q_pkg::t_in make_angles(logic [15:0] r, logic [15:0] p,
                                                 logic [15:0] y);
        e2q_pkg::t_in a;
        a.roll_deg = r;
        a.pitch_deg = p;
        a.yaw_deg = y;
        return a;
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Directed corners, then random angles.
    initial begin
        logic [15:0] corners[10];
        corners = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd11520, -16'sd11520,
                    16'sd5760, 16'h7fff, 16'h8000, 16'sd1, -16'sd1};
        for (int i = 0; i < 10; i++)
            angle_queue.push_back(make_angles(corners[i], corners[(i + 3) % 10],
                                              corners[(i + 7) % 10]));
        angle_queue.push_back(make_angles(16'sd11520, 16'sd5760, 16'sd2880));
        angle_queue.push_back(make_angles(16'sd11521, -16'sd11521, 16'sd11519));
        angle_queue.push_back(make_angles(16'hffff, 16'h0000, 16'h5555));
        angle_queue.push_back(make_angles(16'haaaa, 16'h5555, 16'haaaa));
        for (int i = 0; i < NumRandom; i++)
            angle_queue.push_back(make_angles(random_angle(), random_angle(), random_angle()));
    end

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            i_data <= '0;
            send_gap <= 0;
        end else if (i_valid && !o_ready) begin
            // Hold the request.
        end else if (send_gap > 0) begin
            i_valid <= 0;
            send_gap <= send_gap - 1;
        end else if (angle_queue.size() > 0) begin
            i_valid <= 1;
            i_data <= angle_queue.pop_front();
            send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        end else begin
            i_valid <= 0;
            stimulus_done <= 1;
        end
    end

    // Predict on every accepted request.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            quat_queue.push_back(predict_quaternion(i_data));
            requests_sent <= requests_sent + 1;
        end
    end

    // Receiver with random stalls and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
            take_gap <= 0;
            hold_off <= 0;
        end else if (requests_sent == 200 && hold_off == 0) begin
            hold_off <= 150;
            i_ready <= 0;
        end else if (hold_off > 1) begin
            hold_off <= hold_off - 1;
        end else if (take_gap > 0) begin
            i_ready <= 0;
            take_gap <= take_gap - 1;
        end else begin
            i_ready <= 1;
            if (hold_off == 1) hold_off <= -1;
            if (o_valid && i_ready)
                take_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        end
    end

    // Compare each result with the oldest prediction.
    always @(posedge i_clk) begin
        e2q_pkg::t_out exp_q;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (quat_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", o_data);
            end else begin
                exp_q = quat_queue.pop_front();
                if (exp_q !== o_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp w=%0d x=%0d y=%0d z=%0d, got %0d %0d %0d %0d",
                                 exp_q.quat_w, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z,
                                 o_data.quat_w, o_data.quat_x, o_data.quat_y, o_data.quat_z);
                end
            end
        end
    end

    // Reset, then wait for the queues to drain.
    initial begin
        stimulus_done = 0;
        mismatches = 0;
        results_seen = 0;
        requests_sent = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        wait (stimulus_done && quat_queue.size() == 0);
        repeat (Latency + 10) @(posedge i_clk);
        $display("Converted %0d angle sets, including range corners and a long output stall.",
                 results_seen);
        if (mismatches == 0 && quat_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/e2q_pkg.sv
sv/euler_to_quaternion_unit.sv
sim/tb_euler_to_quaternion_unit.sv
